// File: sv/ssaw_pkg.sv
package ssaw_pkg;

    // Sample and internal formats
    localparam int SAMPLE_BITS    = 24;
    localparam int INT_FRAC       = 27;
    localparam int IN_SHIFT       = INT_FRAC - (SAMPLE_BITS - 1);
    localparam int INT_W          = 32;
    localparam int DIFF_W         = INT_W + 1;
    localparam int L27_W          = SAMPLE_BITS + IN_SHIFT;
    localparam int ACC_W          = 36;

    // Coefficients, unsigned Q.16
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 1;
    localparam int PROD_W         = COEF_W + 1 + DIFF_W;
    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [COEF_W-1:0] REAR_MAX  = COEF_W'(1) << (COEF_FRAC_BITS - 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TAPS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECOR_COEFS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MIX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_A_WT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_WT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_MIX    = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_frame_out;

endpackage

// File: sv/stereo_side_ambience_widener.sv
// Stereo side-ambience widener.
//
// Input channel (i_in_valid / o_in_ready / i_in): one stereo word of two
// signed Q1.23 samples. Output channel (o_out_valid / i_out_ready / o_out):
// one stereo word per input word, saturated Q1.23, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge; write only while the block is idle (not enforced by the block).
//
// One shared multiply-accumulate unit (18x33 multiply, then floor, add and
// saturate) is stepped through eleven operations by a small sequencer, each
// in a multiply phase and then an accumulate phase. A new word is accepted
// only after the previous one has left the final state for the output
// register, which raises o_out_valid. With rear_mix zero the word bypasses
// the unit and state is left alone: it goes from idle to the final state.
// o_in_ready is high only while the sequencer is idle.
//
// The output register holds a finished word until taken; if the receiver
// stalls, the next word is fully computed and then waits for the slot.
// Reset (synchronous, active low) restores register defaults and zeroes
// the filter states and write pointer. The history needs no clearing pass:
// a wrapped flag and the write pointer tell which entries were written,
// and an unwritten entry reads as zero.
module stereo_side_ambience_widener #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ssaw_pkg::t_frame_in                 i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ssaw_pkg::t_frame_out                o_out,
    input  logic                                i_cfg_we,
    input  logic [ssaw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ssaw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = (AW > 8 ? AW : 8) + 1;
    localparam int DELAY_TOP = (HISTORY_DEPTH - 1 < 255) ? HISTORY_DEPTH - 1 : 255;

    localparam int CW  = ssaw_pkg::COEF_W;
    localparam int IW  = ssaw_pkg::INT_W;
    localparam int DW  = ssaw_pkg::DIFF_W;
    localparam int XW  = ssaw_pkg::ACC_W;
    localparam int SB  = ssaw_pkg::SAMPLE_BITS;
    localparam int LW  = ssaw_pkg::L27_W;

    // Sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SIDE  = 4'd1;
    localparam logic [3:0] ST_LP    = 4'd2;
    localparam logic [3:0] ST_HIGH  = 4'd3;
    localparam logic [3:0] ST_DA    = 4'd4;
    localparam logic [3:0] ST_DB    = 4'd5;
    localparam logic [3:0] ST_DMIX  = 4'd6;
    localparam logic [3:0] ST_AMB   = 4'd7;
    localparam logic [3:0] ST_REARL = 4'd8;
    localparam logic [3:0] ST_REARR = 4'd9;
    localparam logic [3:0] ST_OUTL  = 4'd10;
    localparam logic [3:0] ST_OUTR  = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    // ---------------------------------------------------------------- helpers
    function automatic logic [CW-1:0] clamp_one(input logic [CW-1:0] raw);
        clamp_one = (raw > ssaw_pkg::COEF_ONE) ? ssaw_pkg::COEF_ONE : raw;
    endfunction

    function automatic logic signed [DW-1:0] diff(input logic signed [IW-1:0] y,
                                                   input logic signed [IW-1:0] x);
        diff = $signed({y[IW-1], y}) - $signed({x[IW-1], x});
    endfunction

    function automatic logic signed [XW-1:0] ext32(input logic signed [IW-1:0] x);
        ext32 = $signed({{(XW-IW){x[IW-1]}}, x});
    endfunction

    function automatic logic signed [IW-1:0] sat32(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = ext32({1'b0, {(IW-1){1'b1}}});
        lo = ext32({1'b1, {(IW-1){1'b0}}});
        if (v > hi) begin
            sat32 = {1'b0, {(IW-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(IW-1){1'b0}}};
        end else begin
            sat32 = v[IW-1:0];
        end
    endfunction

    function automatic logic signed [SB-1:0] to_out(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        s = v >>> ssaw_pkg::IN_SHIFT;
        if (s > $signed({{(XW-SB+1){1'b0}}, {(SB-1){1'b1}}})) begin
            to_out = {1'b0, {(SB-1){1'b1}}};
        end else if (s < $signed({{(XW-SB+1){1'b1}}, {(SB-1){1'b0}}})) begin
            to_out = {1'b1, {(SB-1){1'b0}}};
        end else begin
            to_out = s[SB-1:0];
        end
    endfunction

    function automatic logic [PW-1:0] clamp_delay(input logic [7:0] d);
        logic [PW-1:0] v;
        v = PW'(d);
        if (v < PW'(1)) begin
            v = PW'(1);
        end
        if (v > PW'(DELAY_TOP)) begin
            v = PW'(DELAY_TOP);
        end
        clamp_delay = v;
    endfunction

    // ------------------------------------------------------ config registers
    logic [CW-1:0] r_low_alpha, r_side_gain, r_high_mix, r_amb_a_wt, r_rear_wt;
    logic [15:0]   r_delay_taps, r_rear_mix;
    logic [2*CW-1:0] r_decor_coefs;

    // -------------------------------------------------------- control, state
    logic [3:0]    r_state, n_state;
    logic          r_phase;          // 0: multiply, 1: accumulate
    logic [AW-1:0] r_wp;
    logic          r_wrapped;
    logic          r_out_valid;

    logic signed [IW-1:0] r_lp, r_da, r_db;

    // ------------------------------------------------------- working values
    logic signed [LW-1:0] r_l27, r_r27;
    logic [CW-1:0]        r_rm;
    logic signed [IW-1:0] r_side, r_high, r_tap_a, r_tap_b;
    logic signed [IW-1:0] r_dmix, r_amb, r_rear_l, r_rear_r;
    logic signed [SB-1:0] r_res_l, r_res_r;
    ssaw_pkg::t_frame_out r_out;

    logic signed [ssaw_pkg::PROD_W-1:0] r_prod;
    logic signed [XW-1:0]               r_base;

    // saturated MAC result, also the history write data
    logic signed [IW-1:0] w_sat;

    // --------------------------------------------------------- history taps
    logic [PW-1:0] w_dly_a, w_dly_b, w_wp_ext;
    logic [PW-1:0] w_ia_ext, w_ib_ext;
    logic [AW-1:0] w_ia, w_ib, w_rd_addr;
    logic          w_va, w_vb;
    logic          w_we;
    logic [IW-1:0] w_rd_data;

    assign w_dly_a  = clamp_delay(r_delay_taps[7:0]);
    assign w_dly_b  = clamp_delay(r_delay_taps[15:8]);
    assign w_wp_ext = PW'(r_wp);
    assign w_ia_ext = (w_wp_ext >= w_dly_a) ? w_wp_ext - w_dly_a
                                            : w_wp_ext + PW'(HISTORY_DEPTH) - w_dly_a;
    assign w_ib_ext = (w_wp_ext >= w_dly_b) ? w_wp_ext - w_dly_b
                                            : w_wp_ext + PW'(HISTORY_DEPTH) - w_dly_b;
    assign w_ia = w_ia_ext[AW-1:0];
    assign w_ib = w_ib_ext[AW-1:0];
    // an entry holds data once the pointer has passed it
    assign w_va = r_wrapped || (w_ia < r_wp);
    assign w_vb = r_wrapped || (w_ib < r_wp);

    // tap A address in the first cycle, tap B right after
    assign w_rd_addr = (r_state == ST_SIDE && !r_phase) ? w_ia : w_ib;
    assign w_we      = (r_state == ST_HIGH) && r_phase;

    ssaw_ram #(
        .WIDTH (IW),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (r_wp),
        .i_wr_data (w_sat),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------ shared MAC unit
    // result = base + floor(c * d / 2^16)
    logic signed [XW-1:0] w_op_base;
    logic [CW-1:0]        w_op_c;
    logic signed [DW-1:0] w_op_d;
    logic signed [ssaw_pkg::PROD_W-1:0] w_prod_sh;
    logic signed [XW-1:0] w_sum;
    logic signed [SB-1:0] w_sum_out;

    always_comb begin
        w_op_base = '0;
        w_op_c    = '0;
        w_op_d    = '0;
        case (r_state)
            ST_SIDE: begin
                w_op_c = clamp_one(r_side_gain);
                w_op_d = DW'($signed({r_l27[LW-1], r_l27}) - $signed({r_r27[LW-1], r_r27}));
            end
            ST_LP: begin
                w_op_base = ext32(r_lp);
                w_op_c    = clamp_one(r_low_alpha);
                w_op_d    = diff(r_side, r_lp);
            end
            ST_HIGH: begin
                w_op_base = ext32(r_side);
                w_op_c    = ssaw_pkg::COEF_ONE;
                w_op_d    = diff('0, r_lp);
            end
            ST_DA: begin
                w_op_base = ext32(r_da);
                w_op_c    = clamp_one(r_decor_coefs[CW-1:0]);
                w_op_d    = diff(r_tap_a, r_da);
            end
            ST_DB: begin
                w_op_base = ext32(r_db);
                w_op_c    = clamp_one(r_decor_coefs[2*CW-1:CW]);
                w_op_d    = diff(r_tap_b, r_db);
            end
            ST_DMIX: begin
                w_op_base = ext32(r_db);
                w_op_c    = clamp_one(r_amb_a_wt);
                w_op_d    = diff(r_da, r_db);
            end
            ST_AMB: begin
                w_op_base = ext32(r_high);
                w_op_c    = clamp_one(r_high_mix);
                w_op_d    = diff(r_dmix, r_high);
            end
            ST_REARL: begin
                w_op_base = ext32(r_da);
                w_op_c    = clamp_one(r_rear_wt);
                w_op_d    = diff(r_amb, r_da);
            end
            ST_REARR: begin
                w_op_base = ext32(r_db);
                w_op_c    = clamp_one(r_rear_wt);
                w_op_d    = diff(r_amb, r_db);
            end
            ST_OUTL: begin
                w_op_base = $signed({{(XW-LW){r_l27[LW-1]}}, r_l27});
                w_op_c    = r_rm;
                w_op_d    = $signed({r_rear_l[IW-1], r_rear_l});
            end
            ST_OUTR: begin
                w_op_base = $signed({{(XW-LW){r_r27[LW-1]}}, r_r27});
                w_op_c    = r_rm;
                w_op_d    = $signed({r_rear_r[IW-1], r_rear_r});
            end
            default: begin
                w_op_base = '0;
            end
        endcase
    end

    assign w_prod_sh = r_prod >>> ssaw_pkg::COEF_FRAC_BITS;
    assign w_sum     = r_base + $signed(w_prod_sh[XW-1:0]);
    assign w_sat     = sat32(w_sum);
    assign w_sum_out = to_out(w_sum);

    // ------------------------------------------------------------ sequencer
    logic w_accept, w_slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_rear_mix == '0) ? ST_FIN : ST_SIDE;
                end
            end
            ST_OUTR: begin
                if (r_phase) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                if (r_phase) begin
                    n_state = r_state + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= 1'b0;
            r_wp          <= '0;
            r_wrapped     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_lp          <= '0;
            r_da          <= '0;
            r_db          <= '0;
            r_low_alpha   <= CW'(1274);
            r_side_gain   <= CW'(65536);
            r_delay_taps  <= 16'd15141;
            r_decor_coefs <= {CW'(32768), CW'(32768)};
            r_high_mix    <= CW'(32768);
            r_amb_a_wt    <= CW'(32768);
            r_rear_wt     <= CW'(32768);
            r_rear_mix    <= 16'd0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssaw_pkg::REG_LOW_ALPHA:   r_low_alpha   <= i_cfg_data[CW-1:0];
                    ssaw_pkg::REG_SIDE_GAIN:   r_side_gain   <= i_cfg_data[CW-1:0];
                    ssaw_pkg::REG_DELAY_TAPS:  r_delay_taps  <= i_cfg_data[15:0];
                    ssaw_pkg::REG_DECOR_COEFS: r_decor_coefs <= i_cfg_data[2*CW-1:0];
                    ssaw_pkg::REG_HIGH_MIX:    r_high_mix    <= i_cfg_data[CW-1:0];
                    ssaw_pkg::REG_AMB_A_WT:    r_amb_a_wt    <= i_cfg_data[CW-1:0];
                    ssaw_pkg::REG_REAR_WT:     r_rear_wt     <= i_cfg_data[CW-1:0];
                    ssaw_pkg::REG_REAR_MIX:    r_rear_mix    <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_FIN && w_slot_free) begin
                r_out_valid <= 1'b1;
            end

            if (r_state != ST_IDLE && r_state != ST_FIN) begin
                r_phase <= !r_phase;
            end

            // filter states and pointer, written only on the full path
            if (r_phase) begin
                case (r_state)
                    ST_LP:  r_lp <= w_sat;
                    ST_HIGH: begin
                        if (r_wp == AW'(HISTORY_DEPTH - 1)) begin
                            r_wp      <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_wp <= r_wp + AW'(1);
                        end
                    end
                    ST_DA:  r_da <= w_sat;
                    ST_DB:  r_db <= w_sat;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_l27   <= $signed({i_in.left_sample, {ssaw_pkg::IN_SHIFT{1'b0}}});
            r_r27   <= $signed({i_in.right_sample, {ssaw_pkg::IN_SHIFT{1'b0}}});
            r_rm    <= (CW'(r_rear_mix) > ssaw_pkg::REAR_MAX) ? ssaw_pkg::REAR_MAX
                                                               : CW'(r_rear_mix);
            r_res_l <= i_in.left_sample;
            r_res_r <= i_in.right_sample;
        end

        if (!r_phase) begin
            r_prod <= $signed({1'b0, w_op_c}) * w_op_d;
            r_base <= w_op_base;
        end

        // history reads are registered and land in the cycle after the address
        if (r_state == ST_SIDE && r_phase) begin
            r_tap_a <= w_va ? $signed(w_rd_data) : '0;
        end
        if (r_state == ST_LP && !r_phase) begin
            r_tap_b <= w_vb ? $signed(w_rd_data) : '0;
        end

        if (r_phase) begin
            case (r_state)
                ST_SIDE:  r_side   <= w_sat;
                ST_HIGH:  r_high   <= w_sat;
                ST_DMIX:  r_dmix   <= w_sat;
                ST_AMB:   r_amb    <= w_sat;
                ST_REARL: r_rear_l <= w_sat;
                ST_REARR: r_rear_r <= w_sat;
                ST_OUTL:  r_res_l  <= w_sum_out;
                ST_OUTR:  r_res_r  <= w_sum_out;
                default: begin
                end
            endcase
        end

        if (r_state == ST_FIN && w_slot_free) begin
            r_out.left_out  <= r_res_l;
            r_out.right_out <= r_res_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/ssaw_ram.sv
module ssaw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/stereo_side_ambience_widener_tb.sv
`timescale 1ns / 1ps

module stereo_side_ambience_widener_tb;

    localparam int HIST_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Spare cycles after the last word before settings change or the run ends
    localparam int SETTLE      = 30;
    localparam int SB          = ssaw_pkg::SAMPLE_BITS;
    localparam int CW          = ssaw_pkg::COEF_W;
    localparam int IDX_W       = ssaw_pkg::CFG_IDX_W;
    localparam int DATA_W      = ssaw_pkg::CFG_DATA_W;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam longint Q31_MAX = 64'sd2147483647;
    localparam longint Q31_MIN = -64'sd2147483648;

    // ---------------------------------------------------------------
    // Clock, reset, DUT connections. Everything driven from time zero.
    // ---------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    ssaw_pkg::t_frame_in   in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ssaw_pkg::t_frame_out  out_word;
    logic                  cfg_we    = 1'b0;
    logic [IDX_W-1:0]      cfg_idx   = '0;
    logic [DATA_W-1:0]     cfg_data  = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    stereo_side_ambience_widener u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor: register shadow and filter state
    // ---------------------------------------------------------------
    logic [CW-1:0]     cf_low_alpha;
    logic [CW-1:0]     cf_side_gain;
    logic [15:0]       cf_delay_taps;
    logic [33:0]       cf_decor_coefs;
    logic [CW-1:0]     cf_high_mix;
    logic [CW-1:0]     cf_amb_a_wt;
    logic [CW-1:0]     cf_rear_wt;
    logic [15:0]       cf_rear_mix;

    int side_lp_st;
    int decor_a_st;
    int decor_b_st;
    int side_hist [HIST_DEPTH];
    int hist_wr_ptr;

    // Expected output words, oldest first
    ssaw_pkg::t_frame_out widened_due [$];

    int  n_fail      = 0;
    int  cycle_count = 0;
    int  rx_hold     = 0;   // receiver hold-off request, in cycles
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;

    function automatic void load_defaults();
        cf_low_alpha   = 17'd1274;
        cf_side_gain   = 17'd65536;
        cf_delay_taps  = 16'd15141;
        cf_decor_coefs = 34'd4295000064;
        cf_high_mix    = 17'd32768;
        cf_amb_a_wt    = 17'd32768;
        cf_rear_wt     = 17'd32768;
        cf_rear_mix    = 16'd0;
        side_lp_st     = 0;
        decor_a_st     = 0;
        decor_b_st     = 0;
        hist_wr_ptr    = 0;
        foreach (side_hist[i]) side_hist[i] = 0;
    endfunction

    function automatic void shadow_write(logic [IDX_W-1:0] idx,
                                         logic [DATA_W-1:0] data);
        case (idx)
            ssaw_pkg::REG_LOW_ALPHA:   cf_low_alpha   = data[CW-1:0];
            ssaw_pkg::REG_SIDE_GAIN:   cf_side_gain   = data[CW-1:0];
            ssaw_pkg::REG_DELAY_TAPS:  cf_delay_taps  = data[15:0];
            ssaw_pkg::REG_DECOR_COEFS: cf_decor_coefs = data[33:0];
            ssaw_pkg::REG_HIGH_MIX:    cf_high_mix    = data[CW-1:0];
            ssaw_pkg::REG_AMB_A_WT:    cf_amb_a_wt    = data[CW-1:0];
            ssaw_pkg::REG_REAR_WT:     cf_rear_wt     = data[CW-1:0];
            ssaw_pkg::REG_REAR_MIX:    cf_rear_mix    = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic int sat32(longint v);
        if (v > Q31_MAX) return int'(Q31_MAX);
        if (v < Q31_MIN) return int'(Q31_MIN);
        return int'(v);
    endfunction

    // Coefficient times Q5.27, floored (arithmetic shift of a signed product)
    function automatic longint qmul(longint c, longint x);
        return (c * x) >>> ssaw_pkg::COEF_FRAC_BITS;
    endfunction

    // x + c*(y - x), saturated
    function automatic int blend(longint c, int x, int y);
        return sat32(longint'(x) + qmul(c, longint'(y) - longint'(x)));
    endfunction

    function automatic longint clip_coef(longint raw, longint top);
        return (raw > top) ? top : raw;
    endfunction

    function automatic int clamp_delay(logic [7:0] d);
        int v;
        v = int'(d);
        if (v < 1) v = 1;
        if (v > HIST_DEPTH - 1) v = HIST_DEPTH - 1;
        return v;
    endfunction

    function automatic logic [SB-1:0] floor_to_q23(longint v);
        longint s;
        s = v >>> ssaw_pkg::IN_SHIFT;
        if (s > longint'(S_MAX)) s = longint'(S_MAX);
        if (s < longint'(S_MIN)) s = longint'(S_MIN);
        return SB'(s);
    endfunction

    // One accepted input word -> one expected output word
    function automatic void widen_frame(ssaw_pkg::t_frame_in f);
        longint     l27, r27, rm, one;
        int         side, high, tap_a, tap_b, dmix, amb, rear_l, rear_r;
        int         ia, ib;
        ssaw_pkg::t_frame_out w;
        one = longint'(ssaw_pkg::COEF_ONE);
        l27 = longint'(f.left_sample) * (longint'(1) << ssaw_pkg::IN_SHIFT);
        r27 = longint'(f.right_sample) * (longint'(1) << ssaw_pkg::IN_SHIFT);
        rm  = clip_coef(longint'(cf_rear_mix), longint'(ssaw_pkg::REAR_MAX));
        if (rm == 0) begin
            // bypass: state untouched
            w.left_out  = floor_to_q23(l27);
            w.right_out = floor_to_q23(r27);
        end else begin
            side = sat32(qmul(clip_coef(longint'(cf_side_gain), one), l27 - r27));
            side_lp_st = blend(clip_coef(longint'(cf_low_alpha), one), side_lp_st, side);
            high = sat32(longint'(side) - longint'(side_lp_st));

            ia = (hist_wr_ptr + HIST_DEPTH - clamp_delay(cf_delay_taps[7:0])) % HIST_DEPTH;
            ib = (hist_wr_ptr + HIST_DEPTH - clamp_delay(cf_delay_taps[15:8])) % HIST_DEPTH;
            tap_a = side_hist[ia];
            tap_b = side_hist[ib];
            side_hist[hist_wr_ptr] = high;
            hist_wr_ptr = (hist_wr_ptr + 1) % HIST_DEPTH;

            decor_a_st = blend(clip_coef(longint'(cf_decor_coefs[16:0]), one),
                               decor_a_st, tap_a);
            decor_b_st = blend(clip_coef(longint'(cf_decor_coefs[33:17]), one),
                               decor_b_st, tap_b);

            dmix   = blend(clip_coef(longint'(cf_amb_a_wt), one), decor_b_st, decor_a_st);
            amb    = blend(clip_coef(longint'(cf_high_mix), one), high, dmix);
            rear_l = blend(clip_coef(longint'(cf_rear_wt), one), decor_a_st, amb);
            rear_r = blend(clip_coef(longint'(cf_rear_wt), one), decor_b_st, amb);

            w.left_out  = floor_to_q23(l27 + qmul(rm, longint'(rear_l)));
            w.right_out = floor_to_q23(r27 + qmul(rm, longint'(rear_r)));
        end
        widened_due.push_back(w);
    endfunction

    // ---------------------------------------------------------------
    // Edge monitor: register writes and accepted input words feed the
    // predictor. Inputs move on the falling edge, so they are stable here.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (cfg_we) shadow_write(cfg_idx, cfg_data);
            if (in_valid && in_ready) widen_frame(in_word);
        end
    end

    // Result check: each accepted output word against the oldest expectation
    always @(posedge i_clk) begin : chk
        ssaw_pkg::t_frame_out want;
        if (rst_n && out_valid && out_ready) begin
            if (widened_due.size() == 0) begin
                $error("output word with none pending: left_out %0d right_out %0d",
                       out_word.left_out, out_word.right_out);
                n_fail++;
            end else begin
                want = widened_due.pop_front();
                if (out_word.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d",
                           want.left_out, out_word.left_out);
                    n_fail++;
                end
                if (out_word.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d",
                           want.right_out, out_word.right_out);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Random gap lengths: mostly short, a few long
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, steady stretches, and on request one long
    // hold-off so the block backs up and drops o_in_ready.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold    = 0;
                stall_left = 0;
            end else if (stall_left != 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one word and hold it until accepted; valid is not lowered here,
    // so back-to-back words keep it high.
    task automatic send_frame(input ssaw_pkg::t_frame_in f);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_word  <= f;
        forever begin
            @(posedge i_clk);
            if (in_ready) break;
        end
    endtask

    task automatic send_pair(input logic signed [SB-1:0] l,
                             input logic signed [SB-1:0] r);
        ssaw_pkg::t_frame_in f;
        f.left_sample  = l;
        f.right_sample = r;
        send_frame(f);
    endtask

    // Registers change only with the block idle (see wait_drained)
    task automatic cfg_write(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic cfg_write_all(input logic [CW-1:0] low_alpha,
                                 input logic [CW-1:0] side_gain,
                                 input logic [15:0] taps,
                                 input logic [33:0] decor,
                                 input logic [CW-1:0] high_mix,
                                 input logic [CW-1:0] amb_wt,
                                 input logic [CW-1:0] rear_wt,
                                 input logic [15:0] rear_mix);
        cfg_write(ssaw_pkg::REG_LOW_ALPHA,   DATA_W'(low_alpha));
        cfg_write(ssaw_pkg::REG_SIDE_GAIN,   DATA_W'(side_gain));
        cfg_write(ssaw_pkg::REG_DELAY_TAPS,  DATA_W'(taps));
        cfg_write(ssaw_pkg::REG_DECOR_COEFS, DATA_W'(decor));
        cfg_write(ssaw_pkg::REG_HIGH_MIX,    DATA_W'(high_mix));
        cfg_write(ssaw_pkg::REG_AMB_A_WT,    DATA_W'(amb_wt));
        cfg_write(ssaw_pkg::REG_REAR_WT,     DATA_W'(rear_wt));
        cfg_write(ssaw_pkg::REG_REAR_MIX,    DATA_W'(rear_mix));
    endtask

    // Stop offering, wait for every pending word, then let the sequencer settle
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (widened_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random audio-like words: full-range noise covers every bit, the rest
    // exercise quiet passages, near-mono, mono, anti-phase and the rails.
    function automatic ssaw_pkg::t_frame_in pick_frame();
        ssaw_pkg::t_frame_in f;
        int                  sel;
        sel = $urandom_range(0, 9);
        f.left_sample  = SB'($urandom);
        f.right_sample = SB'($urandom);
        case (sel)
            4, 5: begin
                f.left_sample  = SB'(int'($urandom_range(0, 8191)) - 4096);
                f.right_sample = SB'(int'($urandom_range(0, 8191)) - 4096);
            end
            6: f.right_sample = f.left_sample
                                + SB'(int'($urandom_range(0, 255)) - 128);
            7: begin
                f.left_sample  = $urandom_range(0, 1) ? S_MAX : S_MIN;
                f.right_sample = $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            8: f.right_sample = -f.left_sample;
            9: f.right_sample = f.left_sample;
            default: ;
        endcase
        return f;
    endfunction

    task automatic run_random(input int count);
        int gap;
        repeat (count) begin
            send_frame(pick_frame());
            if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Q.16 coefficient: mostly in range, with zero, unity and above-unity
    function automatic logic [CW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ssaw_pkg::COEF_ONE;
            2:       return CW'($urandom_range(65537, 131071));
            default: return CW'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [15:0] pick_taps();
        case ($urandom_range(0, 3))
            0:       return {8'($urandom_range(0, 2)), 8'($urandom_range(250, 255))};
            1:       return {8'($urandom_range(1, 16)), 8'($urandom_range(0, 16))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Rear gain: zero now and then for bypass, otherwise up to and past the cap
    function automatic logic [15:0] pick_rear_mix();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd32768;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset settings: rear gain zero, words pass straight through
    task automatic test_bypass_reset();
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair('0, '0);
        send_pair(S_MAX, S_MAX);
        send_pair(-24'sd1, S_MIN);
        wait_drained();
    endtask

    // Default coefficients with the rear path on; five words of swings, silence
    // and a small step, too few to reach the default history taps.
    task automatic test_default_coefs();
        cfg_write(ssaw_pkg::REG_REAR_MIX, DATA_W'(16'd16384));
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair('0, '0);
        send_pair(24'sd1, -24'sd1);
        send_pair(S_MAX, '0);
        wait_drained();
    endtask

    // Every coefficient above unity, rear gain above its cap, both delays
    // zero (clamped to one): hard swings drive internal and output saturation.
    task automatic test_saturated_coefs();
        cfg_write_all(17'h1FFFF, 17'h1FFFF, 16'h0000, 34'h3_FFFF_FFFF,
                      17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair('0, '0);
        wait_drained();
    endtask

    // Zero coefficients, longest delays, rear gain exactly at the cap
    task automatic test_zero_coefs();
        cfg_write_all('0, '0, 16'hFFFF, '0, '0, '0, '0, 16'd32768);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(S_MAX, S_MAX);
        wait_drained();
        cfg_write(ssaw_pkg::REG_SIDE_GAIN, DATA_W'(ssaw_pkg::COEF_ONE));
        send_pair(S_MIN, S_MAX);
        send_pair(24'sd12345, -24'sd54321);
        wait_drained();
    endtask

    // Several random settings, each followed by a burst of random words
    task automatic test_random_settings();
        for (int ph = 0; ph < 9; ph++) begin
            cfg_write_all(pick_coef(), pick_coef(), pick_taps(),
                          {pick_coef(), pick_coef()}, pick_coef(), pick_coef(),
                          pick_coef(), pick_rear_mix());
            run_random(150);
            wait_drained();
        end
    endtask

    // No idling on either side: the block runs at its own pace
    task automatic test_steady_stream();
        cfg_write(ssaw_pkg::REG_REAR_MIX, DATA_W'(16'd20000));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(150);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while words keep coming: the
    // output register and the finished word behind it fill, then o_in_ready
    // stays low until the receiver lets go.
    task automatic test_output_backpressure();
        cfg_write(ssaw_pkg::REG_REAR_MIX, DATA_W'(16'd24576));
        rx_hold    = 500;
        tx_idle_on = 1'b0;
        run_random(80);
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        load_defaults();
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;

        test_bypass_reset();
        test_default_coefs();
        test_saturated_coefs();
        test_zero_coefs();
        test_random_settings();
        test_steady_stream();
        test_output_backpressure();

        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
